### rtl/core/bdfc_pkg.sv
`timescale 1ns / 1ps

package bdfc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam int ADDR_W   = 48;
  localparam int COUNT_W  = 8;
  localparam int TIME_W   = 48;
  localparam int EXPIRY_W = 32;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(60000000);

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

endpackage

### rtl/core/beacon_duplicate_filter_cache.sv
// An item that stops on table entry k (0-based) is walked from entry 0 up to entry k, one
// table read per cycle, with busy high for the whole walk; the result is registered after it.
// A new beat is taken in the cycle the previous result is shown, so the block takes no new
// beat while a walk is in progress; the walk runs on the single read port of the entry memory.
// Reset (rst_n low, synchronous) empties the table and loads the expiry register.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module beacon_duplicate_filter_cache (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bdfc_pkg::ADDR_W-1:0]        in_device_address,
  input  logic [bdfc_pkg::COUNT_W-1:0]       in_sequence_count,
  input  logic [bdfc_pkg::TIME_W-1:0]        in_now_us,
  output logic                               out_valid,
  output logic                               out_is_duplicate,
  input  logic                               cfg_we,
  input  logic [bdfc_pkg::EXPIRY_W-1:0]      cfg_wdata
);

  localparam int N = bdfc_pkg::CACHE_ENTRIES;
  localparam int IW = bdfc_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  bdfc_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] oldest_idx_r, oldest_idx_nxt;
  logic [bdfc_pkg::TIME_W-1:0] oldest_time_r, oldest_time_nxt;
  logic [N-1:0] valid_r, valid_nxt;
  logic [bdfc_pkg::EXPIRY_W-1:0] expiry_r;

  logic [bdfc_pkg::ADDR_W-1:0]  addr_r;
  logic [bdfc_pkg::COUNT_W-1:0] count_r;
  logic [bdfc_pkg::TIME_W-1:0]  now_r;

  logic out_valid_r, out_valid_nxt;
  logic out_dup_r, out_dup_nxt;

  // Entry memory: one write and one registered read per cycle.
  bdfc_pkg::entry_t mem [N];
  bdfc_pkg::entry_t rd_data_r;
  bdfc_pkg::entry_t wr_data;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic          mem_we;

  logic [bdfc_pkg::TIME_W-1:0] age;
  logic addr_hit, count_hit, expired, older;
  logic accept;

  assign accept = start && (state_r == bdfc_pkg::S_IDLE);
  assign busy = (state_r != bdfc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  assign wr_data = {addr_r, count_r, now_r};

  assign addr_hit  = (rd_data_r.address == addr_r);
  assign count_hit = (rd_data_r.count == count_r);
  assign age       = now_r - rd_data_r.stamp;
  assign expired   = (age >= {{(bdfc_pkg::TIME_W - bdfc_pkg::EXPIRY_W){1'b0}}, expiry_r});
  assign older     = (idx_r == '0) || (rd_data_r.stamp < oldest_time_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdfc_pkg::S_IDLE;
      valid_r     <= '0;
      expiry_r    <= bdfc_pkg::EXPIRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        expiry_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    oldest_idx_r  <= oldest_idx_nxt;
    oldest_time_r <= oldest_time_nxt;
    out_dup_r     <= out_dup_nxt;
    if (accept) begin
      addr_r  <= in_device_address;
      count_r <= in_sequence_count;
      now_r   <= in_now_us;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    oldest_idx_nxt  = oldest_idx_r;
    oldest_time_nxt = oldest_time_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = 1'b0;
    out_dup_nxt     = out_dup_r;
    mem_we          = 1'b0;
    wr_idx          = idx_r;
    rd_idx          = idx_r;

    case (state_r)
      bdfc_pkg::S_IDLE: begin
        rd_idx = '0;
        if (start) begin
          idx_nxt   = '0;
          state_nxt = bdfc_pkg::S_WALK;
        end
      end
      bdfc_pkg::S_WALK: begin
        // rd_data_r holds entry idx_r in this cycle.
        if (!valid_r[idx_r]) begin
          mem_we           = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          out_valid_nxt    = 1'b1;
          out_dup_nxt      = 1'b0;
          state_nxt        = bdfc_pkg::S_IDLE;
        end else if (addr_hit) begin
          // A fresh repeat leaves the entry alone; any other hit rewrites it.
          mem_we        = !(count_hit && !expired);
          out_valid_nxt = 1'b1;
          out_dup_nxt   = count_hit && !expired;
          state_nxt     = bdfc_pkg::S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          mem_we        = 1'b1;
          wr_idx        = older ? idx_r : oldest_idx_r;
          out_valid_nxt = 1'b1;
          out_dup_nxt   = 1'b0;
          state_nxt     = bdfc_pkg::S_IDLE;
        end else begin
          if (older) begin
            oldest_idx_nxt  = idx_r;
            oldest_time_nxt = rd_data_r.stamp;
          end
          idx_nxt = idx_r + 1'b1;
          rd_idx  = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = bdfc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/bdfc_port_checker.sv
`timescale 1ns / 1ps

module bdfc_port_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted beat always raises busy in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // The result is shown only once the block has released its input.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while busy");

  // Each walk ends with exactly one result strobe.
  assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> out_valid)
    else $error("walk ended without a result");

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

bind beacon_duplicate_filter_cache bdfc_port_checker u_bdfc_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### verif/tb_beacon_duplicate_filter_cache.sv
`timescale 1ns / 1ps

class beacon_dup_tracker;
  bdfc_pkg::entry_t slots [bdfc_pkg::CACHE_ENTRIES];
  bit slot_used [bdfc_pkg::CACHE_ENTRIES];
  logic [bdfc_pkg::EXPIRY_W-1:0] expiry_us;
  bit pending_dup [$];
  int unsigned fails;

  function new();
    foreach (slot_used[k]) slot_used[k] = 1'b0;
    expiry_us = bdfc_pkg::EXPIRY_RESET;
    fails = 0;
  endfunction

  function void set_expiry(logic [bdfc_pkg::EXPIRY_W-1:0] value);
    expiry_us = value;
  endfunction

  function void fill_slot(int k, logic [bdfc_pkg::ADDR_W-1:0] addr,
                          logic [bdfc_pkg::COUNT_W-1:0] cnt,
                          logic [bdfc_pkg::TIME_W-1:0] now);
    slot_used[k] = 1'b1;
    slots[k].address = addr;
    slots[k].count = cnt;
    slots[k].stamp = now;
  endfunction

  // Walks the cache the same way the block does and updates the copy of it.
  function bit predict_duplicate(logic [bdfc_pkg::ADDR_W-1:0] addr,
                                 logic [bdfc_pkg::COUNT_W-1:0] cnt,
                                 logic [bdfc_pkg::TIME_W-1:0] now);
    int oldest;
    bit have_oldest;
    logic [bdfc_pkg::TIME_W-1:0] oldest_stamp;
    logic [bdfc_pkg::TIME_W-1:0] age;
    oldest = 0;
    have_oldest = 1'b0;
    oldest_stamp = '0;
    for (int k = 0; k < bdfc_pkg::CACHE_ENTRIES; k++) begin
      if (!slot_used[k]) begin
        fill_slot(k, addr, cnt, now);
        return 1'b0;
      end
      if (slots[k].address == addr) begin
        if (slots[k].count == cnt) begin
          // The age wraps at the time width, so a step backwards looks very old.
          age = now - slots[k].stamp;
          if (age >= bdfc_pkg::TIME_W'(expiry_us)) begin
            slots[k].stamp = now;
            return 1'b0;
          end
          return 1'b1;
        end
        slots[k].count = cnt;
        slots[k].stamp = now;
        return 1'b0;
      end
      if (!have_oldest || slots[k].stamp < oldest_stamp) begin
        have_oldest = 1'b1;
        oldest = k;
        oldest_stamp = slots[k].stamp;
      end
    end
    fill_slot(oldest, addr, cnt, now);
    return 1'b0;
  endfunction

  function void note_beat(logic [bdfc_pkg::ADDR_W-1:0] addr,
                          logic [bdfc_pkg::COUNT_W-1:0] cnt,
                          logic [bdfc_pkg::TIME_W-1:0] now);
    pending_dup.push_back(predict_duplicate(addr, cnt, now));
  endfunction

  function void check_result(logic dup);
    bit want;
    if (pending_dup.size() == 0) begin
      $error("is_duplicate: expected nothing, actual %0b", dup);
      fails++;
      return;
    end
    want = pending_dup.pop_front();
    if (dup !== want) begin
      $error("is_duplicate: expected %0b, actual %0b", want, dup);
      fails++;
    end
  endfunction
endclass

module tb_beacon_duplicate_filter_cache;
  localparam int ADDR_W   = bdfc_pkg::ADDR_W;
  localparam int COUNT_W  = bdfc_pkg::COUNT_W;
  localparam int TIME_W   = bdfc_pkg::TIME_W;
  localparam int EXPIRY_W = bdfc_pkg::EXPIRY_W;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ADDR_W-1:0]   in_device_address;
  logic [COUNT_W-1:0]  in_sequence_count;
  logic [TIME_W-1:0]   in_now_us;
  logic                out_valid;
  logic                out_is_duplicate;
  logic                cfg_we;
  logic [EXPIRY_W-1:0] cfg_wdata;

  beacon_dup_tracker dup_log;
  int idle_pct;

  beacon_duplicate_filter_cache dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_device_address (in_device_address),
    .in_sequence_count (in_sequence_count),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_is_duplicate  (out_is_duplicate),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      dup_log.check_result(out_is_duplicate);
    end
  end

  task automatic idle_gap();
    int n;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beacon(logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt,
                             logic [TIME_W-1:0] now);
    idle_gap();
    start <= 1'b1;
    in_device_address <= addr;
    in_sequence_count <= cnt;
    in_now_us <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    dup_log.note_beat(addr, cnt, now);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (dup_log.pending_dup.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_expiry(logic [EXPIRY_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    dup_log.set_expiry(value);
  endtask

  task automatic run_random_beacons(int n, logic [TIME_W-1:0] base_now);
    logic [ADDR_W-1:0]  pool_addr [24];
    logic [COUNT_W-1:0] pool_cnt [24];
    logic [TIME_W-1:0]  now;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] cnt;
    int i;
    int r;
    pool_addr[0] = '0;
    pool_addr[1] = '1;
    for (int k = 2; k < 24; k++) pool_addr[k] = ADDR_W'({$urandom, $urandom});
    foreach (pool_cnt[k]) pool_cnt[k] = COUNT_W'($urandom);
    now = base_now;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 25) begin
        now = now;
      end else if (r < 65) begin
        now = now + TIME_W'($urandom_range(1, 64));
      end else if (r < 80) begin
        // Land right around the expiry boundary.
        now = now + TIME_W'(dup_log.expiry_us) + TIME_W'($urandom_range(2)) - TIME_W'(1);
      end else if (r < 90) begin
        now = now + TIME_W'($urandom);
      end else if (r < 95) begin
        now = now - TIME_W'($urandom_range(1, 1000));
      end else begin
        now = TIME_W'({$urandom, $urandom});
      end
      r = $urandom_range(99);
      if (r < 75) i = $urandom_range(11);
      else if (r < 95) i = $urandom_range(23);
      else i = -1;
      if (i < 0) begin
        addr = ADDR_W'({$urandom, $urandom});
        cnt = COUNT_W'($urandom);
      end else begin
        addr = pool_addr[i];
        cnt = $urandom_range(1) ? pool_cnt[i] : COUNT_W'($urandom);
        pool_cnt[i] = cnt;
      end
      send_beacon(addr, cnt, now);
    end
  endtask

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_device_address = '0;
    in_sequence_count = '0;
    in_now_us = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_pct = 33;
    dup_log = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part runs at the reset expiry of sixty seconds.
    send_beacon('0, 8'h00, 48'd0);
    send_beacon('0, 8'h00, 48'd1);
    send_beacon('1, 8'hff, 48'd2);
    send_beacon('1, 8'hff, 48'd3);
    send_beacon('1, 8'hfe, 48'd4);
    send_beacon('0, 8'h00, 48'd60000001);
    send_beacon('0, 8'h00, 48'd60000002);
    // Time stepping backwards makes the repeat look expired.
    send_beacon('0, 8'h00, 48'd5);
    for (int k = 0; k < 14; k++) begin
      send_beacon(48'h0000_1000_0000 + ADDR_W'(k), COUNT_W'(k), 48'd100);
    end
    // The cache is full now; new addresses evict the oldest, equal stamps go low index.
    send_beacon(48'h5a5a_0000_0001, 8'h11, 48'd100);
    send_beacon(48'h5a5a_0000_0002, 8'h22, 48'd100);
    send_beacon(48'h5a5a_0000_0003, 8'h33, 48'd100);

    write_expiry('0);
    run_random_beacons(260, TIME_W'({$urandom, $urandom}));
    write_expiry('1);
    run_random_beacons(260, TIME_W'({$urandom, $urandom}));
    write_expiry(32'd1000);
    run_random_beacons(260, 48'hffff_ffff_fc00);
    idle_pct = 0;
    write_expiry(32'd60000000);
    run_random_beacons(260, TIME_W'({$urandom, $urandom}));
    idle_pct = 33;
    write_expiry($urandom_range(1, 5000));
    run_random_beacons(260, TIME_W'({$urandom, $urandom}));
    write_expiry($urandom);
    run_random_beacons(260, TIME_W'({$urandom, $urandom}));

    drain();
    repeat (20) @(posedge clk);
    if (dup_log.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
